// File: rtl/cdbr_pkg.sv
package cdbr_pkg;

    localparam int ADDR_W    = 14;
    localparam int DATA_W    = 16;
    localparam int RES_W     = 15;
    localparam int DIV_W     = 6;
    localparam int DIV_CNT_W = $clog2(ADDR_W);
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 6;

    typedef logic [1:0] op_t;
    localparam op_t OP_LOAD_ACT  = 2'd0;
    localparam op_t OP_LOAD_WGT  = 2'd1;
    localparam op_t OP_LOAD_BIAS = 2'd2;
    localparam op_t OP_COMPUTE   = 2'd3;

    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
    localparam cfg_idx_t REG_IN_HEIGHT   = 3'd0;
    localparam cfg_idx_t REG_IN_WIDTH    = 3'd1;
    localparam cfg_idx_t REG_CHANNELS    = 3'd2;
    localparam cfg_idx_t REG_KERNEL_ROWS = 3'd3;
    localparam cfg_idx_t REG_KERNEL_COLS = 3'd4;
    localparam cfg_idx_t REG_FILTERS     = 3'd5;
    localparam cfg_idx_t REG_BIAS_ENABLE = 3'd6;

    localparam logic [RES_W-1:0] RES_MAX = {RES_W{1'b1}};

    typedef struct packed {
        logic clear;
        logic tap;
        logic bias_add;
    } mac_ctrl_t;

endpackage

// File: rtl/conv2d_valid_bias_relu_core.sv
// Channel   Handshake               Payload
// in        in_valid / in_stall     op, addr, value
// out       out_valid / out_stall   result, out_index, status
// cfg       cfg_valid / cfg_ready   cfg_index, cfg_data
//
// A compute runs two 14-step divides to split the index, the base-address setup
// states, then one multiply-accumulate per kernel tap on the single multiplier,
// a drain of the multiply pipeline and the optional bias add.
// The input stalls while a compute is in flight; a waiting result does not block loads.
// Reset idles control, sets config regs to 1; stores hold nothing valid until loaded.
module conv2d_valid_bias_relu_core #(
    parameter int MAX_HEIGHT   = 32,
    parameter int MAX_WIDTH    = 32,
    parameter int MAX_CHANNELS = 16,
    parameter int MAX_KERNEL   = 5,
    parameter int MAX_FILTERS  = 16
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  cdbr_pkg::op_t                        op,
    input  logic [cdbr_pkg::ADDR_W-1:0]          addr,
    input  logic signed [cdbr_pkg::DATA_W-1:0]   value,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic [cdbr_pkg::RES_W-1:0]           result,
    output logic [cdbr_pkg::ADDR_W-1:0]          out_index,
    output logic                                 status,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  cdbr_pkg::cfg_idx_t                   cfg_index,
    input  logic [cdbr_pkg::CFG_DAT_W-1:0]       cfg_data
);
    import cdbr_pkg::*;

    localparam int ACT_DEPTH  = MAX_HEIGHT * MAX_WIDTH * MAX_CHANNELS;
    localparam int WGT_DEPTH  = MAX_KERNEL * MAX_KERNEL * MAX_CHANNELS * MAX_FILTERS;
    localparam int BIAS_DEPTH = MAX_FILTERS;
    localparam int ACT_AW     = (ACT_DEPTH > 1) ? $clog2(ACT_DEPTH) : 1;
    localparam int WGT_AW     = (WGT_DEPTH > 1) ? $clog2(WGT_DEPTH) : 1;
    localparam int BIAS_AW    = (BIAS_DEPTH > 1) ? $clog2(BIAS_DEPTH) : 1;
    localparam int ACC_W      = 2 * DATA_W + $clog2(MAX_KERNEL * MAX_KERNEL * MAX_CHANNELS + 1) + 2;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_DIV1   = 4'd1;
    localparam logic [3:0] S_DIV2   = 4'd2;
    localparam logic [3:0] S_BASE1  = 4'd3;
    localparam logic [3:0] S_BASE2  = 4'd4;
    localparam logic [3:0] S_RUN    = 4'd5;
    localparam logic [3:0] S_DRAIN  = 4'd6;
    localparam logic [3:0] S_BIAS   = 4'd7;
    localparam logic [3:0] S_FINISH = 4'd8;

    logic [5:0] ih_reg, iw_reg;
    logic [4:0] ch_reg, nf_reg;
    logic [2:0] kr_reg, kc_reg;
    logic       be_reg;

    logic [3:0]        state_reg, state_next;
    logic              err_reg, err_next;
    logic [ADDR_W-1:0] addr_reg, addr_next;
    logic [4:0]        f_reg, f_next;
    logic [DIV_W-1:0]  ox_reg, ox_next;
    logic [ADDR_W-1:0] oy_reg, oy_next;
    logic [ACT_AW-1:0] t_reg, t_next;
    logic [ACT_AW-1:0] iwch_reg, iwch_next;
    logic [ACT_AW-1:0] ai_reg, ai_next;
    logic [ACT_AW-1:0] rb_reg, rb_next;
    logic [WGT_AW-1:0] wi_reg, wi_next;
    logic [4:0]        c_reg, c_next;
    logic [2:0]        kx_reg, kx_next;
    logic [2:0]        ky_reg, ky_next;

    logic              out_valid_reg, out_valid_next;
    logic [RES_W-1:0]  result_reg, result_next;
    logic [ADDR_W-1:0] out_index_reg, out_index_next;
    logic              status_reg, status_next;

    logic              accept, cfg_ok;
    logic [5:0]        oh, ow;
    logic              div_start, div_done;
    logic [ADDR_W-1:0] div_dividend, div_quot;
    logic [DIV_W-1:0]  div_divisor, div_rem;
    mac_ctrl_t         mac_ctrl;
    logic              mac_busy;
    logic [RES_W-1:0]  mac_result;
    logic signed [DATA_W-1:0] act_q, wgt_q, bias_q;

    assign in_stall  = (state_reg != S_IDLE);
    assign accept    = in_valid && !in_stall;
    assign cfg_ready = 1'b1;

    assign oh = 6'(ih_reg - {3'd0, kr_reg} + 6'd1);
    assign ow = 6'(iw_reg - {3'd0, kc_reg} + 6'd1);

    assign cfg_ok = (ih_reg >= 6'd1) && (32'(ih_reg) <= MAX_HEIGHT)
                 && (iw_reg >= 6'd1) && (32'(iw_reg) <= MAX_WIDTH)
                 && (ch_reg >= 5'd1) && (32'(ch_reg) <= MAX_CHANNELS)
                 && (kr_reg >= 3'd1) && (32'(kr_reg) <= MAX_KERNEL) && ({3'd0, kr_reg} <= ih_reg)
                 && (kc_reg >= 3'd1) && (32'(kc_reg) <= MAX_KERNEL) && ({3'd0, kc_reg} <= iw_reg)
                 && (nf_reg >= 5'd1) && (32'(nf_reg) <= MAX_FILTERS);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ih_reg <= 6'd1;
            iw_reg <= 6'd1;
            ch_reg <= 5'd1;
            kr_reg <= 3'd1;
            kc_reg <= 3'd1;
            nf_reg <= 5'd1;
            be_reg <= 1'b1;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_IN_HEIGHT:   ih_reg <= cfg_data;
                REG_IN_WIDTH:    iw_reg <= cfg_data;
                REG_CHANNELS:    ch_reg <= cfg_data[4:0];
                REG_KERNEL_ROWS: kr_reg <= cfg_data[2:0];
                REG_KERNEL_COLS: kc_reg <= cfg_data[2:0];
                REG_FILTERS:     nf_reg <= cfg_data[4:0];
                REG_BIAS_ENABLE: be_reg <= cfg_data[0];
                default:         ;
            endcase
        end
    end

    // first divide splits off the filter, second splits row from column
    assign div_dividend = (state_reg == S_IDLE) ? addr : div_quot;
    assign div_divisor  = (state_reg == S_IDLE) ? {1'b0, nf_reg} : ow;

    always_comb
    begin
        state_next     = state_reg;
        err_next       = err_reg;
        addr_next      = addr_reg;
        f_next         = f_reg;
        ox_next        = ox_reg;
        oy_next        = oy_reg;
        t_next         = t_reg;
        iwch_next      = iwch_reg;
        ai_next        = ai_reg;
        rb_next        = rb_reg;
        wi_next        = wi_reg;
        c_next         = c_reg;
        kx_next        = kx_reg;
        ky_next        = ky_reg;
        out_valid_next = out_valid_reg;
        result_next    = result_reg;
        out_index_next = out_index_reg;
        status_next    = status_reg;
        div_start      = 1'b0;
        mac_ctrl       = '0;

        if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept && (op == OP_COMPUTE))
                begin
                    addr_next = addr;
                    if (cfg_ok)
                    begin
                        err_next   = 1'b0;
                        div_start  = 1'b1;
                        state_next = S_DIV1;
                    end
                    else
                    begin
                        err_next   = 1'b1;
                        state_next = S_FINISH;
                    end
                end
            end
            S_DIV1:
            begin
                if (div_done)
                begin
                    f_next     = div_rem[4:0];
                    div_start  = 1'b1;
                    state_next = S_DIV2;
                end
            end
            S_DIV2:
            begin
                if (div_done)
                begin
                    ox_next = div_rem;
                    oy_next = div_quot;
                    // row beyond the output height means the index is out of range
                    if (div_quot >= ADDR_W'(oh))
                    begin
                        err_next   = 1'b1;
                        state_next = S_FINISH;
                    end
                    else
                        state_next = S_BASE1;
                end
            end
            S_BASE1:
            begin
                t_next     = ACT_AW'(32'(oy_reg) * 32'(iw_reg) + 32'(ox_reg));
                iwch_next  = ACT_AW'(32'(iw_reg) * 32'(ch_reg));
                state_next = S_BASE2;
            end
            S_BASE2:
            begin
                ai_next       = ACT_AW'(32'(t_reg) * 32'(ch_reg));
                rb_next       = ACT_AW'(32'(t_reg) * 32'(ch_reg));
                wi_next       = WGT_AW'(f_reg);
                c_next        = '0;
                kx_next       = '0;
                ky_next       = '0;
                mac_ctrl.clear = 1'b1;
                state_next    = S_RUN;
            end
            S_RUN:
            begin
                mac_ctrl.tap = 1'b1;
                wi_next      = WGT_AW'(wi_reg + WGT_AW'(nf_reg));
                ai_next      = ai_reg + 1'b1;
                if (c_reg + 5'd1 < ch_reg)
                    c_next = c_reg + 5'd1;
                else
                begin
                    c_next = '0;
                    if (kx_reg + 3'd1 < kc_reg)
                        kx_next = kx_reg + 3'd1;
                    else
                    begin
                        kx_next = '0;
                        if (ky_reg + 3'd1 < kr_reg)
                        begin
                            ky_next = ky_reg + 3'd1;
                            rb_next = rb_reg + iwch_reg;
                            ai_next = rb_reg + iwch_reg;
                        end
                        else
                            state_next = S_DRAIN;
                    end
                end
            end
            S_DRAIN:
            begin
                if (!mac_busy)
                    state_next = S_BIAS;
            end
            S_BIAS:
            begin
                mac_ctrl.bias_add = be_reg;
                state_next        = S_FINISH;
            end
            S_FINISH:
            begin
                // hold until the output register is free
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    result_next    = err_reg ? '0 : mac_result;
                    out_index_next = addr_reg;
                    status_next    = err_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            err_reg       <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            err_reg       <= err_next;
        end
    end

    always_ff @(posedge clk)
    begin
        addr_reg      <= addr_next;
        f_reg         <= f_next;
        ox_reg        <= ox_next;
        oy_reg        <= oy_next;
        t_reg         <= t_next;
        iwch_reg      <= iwch_next;
        ai_reg        <= ai_next;
        rb_reg        <= rb_next;
        wi_reg        <= wi_next;
        c_reg         <= c_next;
        kx_reg        <= kx_next;
        ky_reg        <= ky_next;
        result_reg    <= result_next;
        out_index_reg <= out_index_next;
        status_reg    <= status_next;
    end

    assign out_valid = out_valid_reg;
    assign result    = result_reg;
    assign out_index = out_index_reg;
    assign status    = status_reg;

    cdbr_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quot     (div_quot),
        .rem      (div_rem)
    );

    cdbr_stores #(
        .ACT_DEPTH  (ACT_DEPTH),
        .WGT_DEPTH  (WGT_DEPTH),
        .BIAS_DEPTH (BIAS_DEPTH),
        .ACT_AW     (ACT_AW),
        .WGT_AW     (WGT_AW),
        .BIAS_AW    (BIAS_AW)
    ) u_stores (
        .clk        (clk),
        .wr_en      (accept),
        .wr_op      (op),
        .wr_addr    (addr),
        .wr_data    (value),
        .act_raddr  (ai_reg),
        .wgt_raddr  (wi_reg),
        .bias_raddr (BIAS_AW'(f_reg)),
        .act_q      (act_q),
        .wgt_q      (wgt_q),
        .bias_q     (bias_q)
    );

    cdbr_mac #(
        .ACC_W (ACC_W)
    ) u_mac (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (mac_ctrl),
        .act_q  (act_q),
        .wgt_q  (wgt_q),
        .bias_q (bias_q),
        .busy   (mac_busy),
        .result (mac_result)
    );

    a_compute_stalls: assert property (@(posedge clk) disable iff (!rst_n)
        accept && (op == OP_COMPUTE) |=> in_stall)
        else $error("input not stalled after compute transaction");

    a_idle_mac_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> !mac_busy)
        else $error("multiply pipeline active while idle");

    a_bias_after_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_BIAS) |-> !mac_busy && $past(state_reg) == S_DRAIN)
        else $error("bias added before taps drained");

    a_finish_loads_out: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FINISH) && !(out_valid_reg && out_stall) |=> out_valid_reg)
        else $error("finished compute produced no result");

    a_run_channel_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RUN) |-> (c_reg < ch_reg) && (kx_reg < kc_reg) && (ky_reg < kr_reg))
        else $error("tap counter out of range");

endmodule

// File: rtl/cdbr_div.sv
module cdbr_div (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [cdbr_pkg::ADDR_W-1:0]   dividend,
    input  logic [cdbr_pkg::DIV_W-1:0]    divisor,
    output logic                          done,
    output logic [cdbr_pkg::ADDR_W-1:0]   quot,
    output logic [cdbr_pkg::DIV_W-1:0]    rem
);
    import cdbr_pkg::*;

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [DIV_W-1:0]     rem_reg, rem_next;
    logic [ADDR_W-1:0]    quo_reg, quo_next;
    logic [DIV_W-1:0]     dvs_reg, dvs_next;
    logic [DIV_W:0]       trial;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        trial     = {rem_reg, quo_reg[ADDR_W-1]};
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            quo_next  = dividend;
            dvs_next  = divisor;
        end
        else if (busy_reg)
        begin
            // one restoring step per cycle, quotient bits shift in from the right
            if (trial >= {1'b0, dvs_reg})
            begin
                rem_next = DIV_W'(trial - {1'b0, dvs_reg});
                quo_next = {quo_reg[ADDR_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[DIV_W-1:0];
                quo_next = {quo_reg[ADDR_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == DIV_CNT_W'(ADDR_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign done = done_reg;
    assign quot = quo_reg;
    assign rem  = rem_reg;

endmodule

// File: rtl/cdbr_stores.sv
module cdbr_stores #(
    parameter int ACT_DEPTH  = 16384,
    parameter int WGT_DEPTH  = 6400,
    parameter int BIAS_DEPTH = 16,
    parameter int ACT_AW     = 14,
    parameter int WGT_AW     = 13,
    parameter int BIAS_AW    = 4
) (
    input  logic                                clk,
    input  logic                                wr_en,
    input  cdbr_pkg::op_t                       wr_op,
    input  logic [cdbr_pkg::ADDR_W-1:0]         wr_addr,
    input  logic signed [cdbr_pkg::DATA_W-1:0]  wr_data,
    input  logic [ACT_AW-1:0]                   act_raddr,
    input  logic [WGT_AW-1:0]                   wgt_raddr,
    input  logic [BIAS_AW-1:0]                  bias_raddr,
    output logic signed [cdbr_pkg::DATA_W-1:0]  act_q,
    output logic signed [cdbr_pkg::DATA_W-1:0]  wgt_q,
    output logic signed [cdbr_pkg::DATA_W-1:0]  bias_q
);
    import cdbr_pkg::*;

    logic signed [DATA_W-1:0] act_mem  [ACT_DEPTH];
    logic signed [DATA_W-1:0] wgt_mem  [WGT_DEPTH];
    logic signed [DATA_W-1:0] bias_mem [BIAS_DEPTH];

    logic act_we, wgt_we, bias_we;

    // drop loads beyond the store depth
    assign act_we  = wr_en && (wr_op == OP_LOAD_ACT)  && (32'(wr_addr) < ACT_DEPTH);
    assign wgt_we  = wr_en && (wr_op == OP_LOAD_WGT)  && (32'(wr_addr) < WGT_DEPTH);
    assign bias_we = wr_en && (wr_op == OP_LOAD_BIAS) && (32'(wr_addr) < BIAS_DEPTH);

    always_ff @(posedge clk)
    begin
        if (act_we)
            act_mem[ACT_AW'(wr_addr)] <= wr_data;
        act_q <= act_mem[act_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (wgt_we)
            wgt_mem[WGT_AW'(wr_addr)] <= wr_data;
        wgt_q <= wgt_mem[wgt_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (bias_we)
            bias_mem[BIAS_AW'(wr_addr)] <= wr_data;
        bias_q <= bias_mem[bias_raddr];
    end

endmodule

// File: rtl/cdbr_mac.sv
module cdbr_mac #(
    parameter int ACC_W = 48
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  cdbr_pkg::mac_ctrl_t                 ctrl,
    input  logic signed [cdbr_pkg::DATA_W-1:0]  act_q,
    input  logic signed [cdbr_pkg::DATA_W-1:0]  wgt_q,
    input  logic signed [cdbr_pkg::DATA_W-1:0]  bias_q,
    output logic                                busy,
    output logic [cdbr_pkg::RES_W-1:0]          result
);
    import cdbr_pkg::*;

    localparam int PROD_W = 2 * DATA_W;

    logic                     mem_v_reg, prod_v_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [ACC_W-1:0]  acc_reg, acc_next;

    always_comb
    begin
        acc_next = acc_reg;
        if (ctrl.clear)
            acc_next = '0;
        else if (prod_v_reg)
            acc_next = acc_reg + {{(ACC_W-PROD_W){prod_reg[PROD_W-1]}}, prod_reg};
        else if (ctrl.bias_add)
            acc_next = acc_reg + {{(ACC_W-DATA_W-8){bias_q[DATA_W-1]}}, bias_q, 8'd0};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mem_v_reg  <= 1'b0;
            prod_v_reg <= 1'b0;
        end
        else
        begin
            mem_v_reg  <= ctrl.tap;
            prod_v_reg <= mem_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_v_reg)
            prod_reg <= act_q * wgt_q;
        acc_reg <= acc_next;
    end

    // ReLU, drop 8 fraction bits, saturate
    always_comb
    begin
        if (acc_reg[ACC_W-1])
            result = '0;
        else if (|acc_reg[ACC_W-2:RES_W+8])
            result = RES_MAX;
        else
            result = acc_reg[RES_W+7:8];
    end

    assign busy = mem_v_reg | prod_v_reg;

endmodule

// File: bench/testbench.sv
`default_nettype none

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import cdbr_pkg::*;

    localparam int ACT_DEPTH  = 32 * 32 * 16;
    localparam int WGT_DEPTH  = 5 * 5 * 16 * 16;
    localparam int BIAS_DEPTH = 16;
    localparam int NUM_REGS   = 7;

    typedef struct {
        logic [RES_W-1:0]  result;
        logic [ADDR_W-1:0] index;
        logic              status;
    } conv_out_t;

    typedef struct {
        op_t               op;
        logic [ADDR_W-1:0] addr;
        logic [15:0]       value;
        bit                typed;
        logic [RES_W-1:0]  result;
        logic              status;
    } stim_row_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    op_t                   op = OP_LOAD_ACT;
    logic [ADDR_W-1:0]     addr = '0;
    logic signed [DATA_W-1:0] value = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    logic [RES_W-1:0]      result;
    logic [ADDR_W-1:0]     out_index;
    logic                  status;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    cfg_idx_t              cfg_index = '0;
    logic [CFG_DAT_W-1:0]  cfg_data = '0;

    conv2d_valid_bias_relu_core dut (.*);

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    initial
    begin
        #30ms;
        $display("conv2d_valid_bias_relu_core regression: fail");
        $finish;
    end

    // shadow of the block's stores and registers
    logic signed [15:0] act_mem  [ACT_DEPTH];
    logic signed [15:0] wgt_mem  [WGT_DEPTH];
    logic signed [15:0] bias_mem [BIAS_DEPTH];
    bit                 act_wr   [ACT_DEPTH];
    bit                 wgt_wr   [WGT_DEPTH];
    bit                 bias_wr  [BIAS_DEPTH];
    int                 shape    [NUM_REGS];
    const int           reg_mask [NUM_REGS] = '{63, 63, 31, 7, 7, 31, 1};

    conv_out_t pending_outputs[$];
    int        mismatches = 0;
    bit        quiet = 1'b0;

    function automatic bit shape_legal();
        if (shape[REG_IN_HEIGHT] < 1 || shape[REG_IN_HEIGHT] > 32) return 0;
        if (shape[REG_IN_WIDTH] < 1 || shape[REG_IN_WIDTH] > 32) return 0;
        if (shape[REG_CHANNELS] < 1 || shape[REG_CHANNELS] > 16) return 0;
        if (shape[REG_KERNEL_ROWS] < 1 || shape[REG_KERNEL_ROWS] > 5 ||
            shape[REG_KERNEL_ROWS] > shape[REG_IN_HEIGHT]) return 0;
        if (shape[REG_KERNEL_COLS] < 1 || shape[REG_KERNEL_COLS] > 5 ||
            shape[REG_KERNEL_COLS] > shape[REG_IN_WIDTH]) return 0;
        if (shape[REG_FILTERS] < 1 || shape[REG_FILTERS] > 16) return 0;
        return 1;
    endfunction

    function automatic int output_count();
        if (!shape_legal()) return 0;
        return (shape[REG_IN_HEIGHT] - shape[REG_KERNEL_ROWS] + 1) *
               (shape[REG_IN_WIDTH] - shape[REG_KERNEL_COLS] + 1) * shape[REG_FILTERS];
    endfunction

    // check = 1: report whether every entry the output reads has been loaded
    function automatic bit walk_window(int a, bit check, output longint acc);
        int iw, ch, kr, kc, nf, ow, f, ox, oy, ai, wi;
        iw = shape[REG_IN_WIDTH];
        ch = shape[REG_CHANNELS];
        kr = shape[REG_KERNEL_ROWS];
        kc = shape[REG_KERNEL_COLS];
        nf = shape[REG_FILTERS];
        ow = iw - kc + 1;
        f  = a % nf;
        ox = (a / nf) % ow;
        oy = (a / nf) / ow;
        acc = 0;
        for (int ky = 0; ky < kr; ky++)
            for (int kx = 0; kx < kc; kx++)
                for (int c = 0; c < ch; c++)
                begin
                    ai = ((oy + ky) * iw + ox + kx) * ch + c;
                    wi = ((ky * kc + kx) * ch + c) * nf + f;
                    if (check && !(act_wr[ai] && wgt_wr[wi])) return 0;
                    acc += longint'(act_mem[ai]) * longint'(wgt_mem[wi]);
                end
        if (shape[REG_BIAS_ENABLE] == 1)
        begin
            if (check && !bias_wr[f]) return 0;
            acc += longint'(bias_mem[f]) * 256;
        end
        return 1;
    endfunction

    function automatic conv_out_t conv_output(logic [ADDR_W-1:0] a);
        conv_out_t e;
        longint    acc;
        longint    q;
        e.result = '0;
        e.index  = a;
        e.status = 1'b1;
        if (int'(a) >= output_count()) return e;
        void'(walk_window(int'(a), 0, acc));
        if (acc < 0) acc = 0;
        q = acc >>> 8;
        e.result = (q > 32767) ? RES_MAX : RES_W'(q);
        e.status = 1'b0;
        return e;
    endfunction

    function automatic void apply_item(op_t o, logic [ADDR_W-1:0] a, logic [15:0] v);
        case (o)
            OP_LOAD_ACT:
            begin
                act_mem[a] = v;
                act_wr[a]  = 1;
            end
            OP_LOAD_WGT:
                if (a < WGT_DEPTH)
                begin
                    wgt_mem[a] = v;
                    wgt_wr[a]  = 1;
                end
            OP_LOAD_BIAS:
                if (a < BIAS_DEPTH)
                begin
                    bias_mem[a] = v;
                    bias_wr[a]  = 1;
                end
            default:
                pending_outputs.push_back(conv_output(a));
        endcase
    endfunction

    function automatic logic [15:0] rand_q88();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick < 2)
        begin
            case ($urandom_range(0, 3))
                0: return 16'h8000;
                1: return 16'h7FFF;
                2: return 16'h0000;
                default: return 16'hFFFF;
            endcase
        end
        if (pick < 6) return 16'($signed($urandom_range(0, 1023)) - 512);
        return 16'($urandom);
    endfunction

    task automatic report(string what, int got, int want);
        $display("%0t: output mismatch on %s: got %0d, want %0d", $realtime, what, got, want);
        mismatches++;
    endtask

    // output side: stall a random number of cycles per transaction
    initial
    begin
        int n;
        @(posedge rst_n);
        forever
        begin
            n = quiet ? 0 : $urandom_range(0, 14);
            out_stall <= (n > 0);
            repeat (n) @(posedge clk);
            if (n > 0) out_stall <= 1'b0;
            do @(posedge clk); while (!out_valid);
        end
    end

    always @(posedge clk)
    begin
        conv_out_t e;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_outputs.size() == 0)
                report("unexpected transaction", int'(out_index), -1);
            else
            begin
                e = pending_outputs.pop_front();
                if (result !== e.result) report("result", int'(result), int'(e.result));
                if (out_index !== e.index)
                    report("out_index", int'(out_index), int'(e.index));
                if (status !== e.status) report("status", int'(status), int'(e.status));
            end
        end
    end

    task automatic send(op_t o, logic [ADDR_W-1:0] a, logic [15:0] v, bit typed = 0,
                        logic [RES_W-1:0] res = '0, logic st = 1'b0);
        int gap;
        conv_out_t e;
        gap = quiet ? 0 : $urandom_range(0, 14);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        op       <= o;
        addr     <= a;
        value    <= v;
        do @(posedge clk); while (in_stall);
        if (typed && o == OP_COMPUTE)
        begin
            e.result = res;
            e.index  = a;
            e.status = st;
            pending_outputs.push_back(e);
        end
        else
            apply_item(o, a, v);
    endtask

    // hold off until every output is back and the block has gone quiet
    task automatic drain();
        in_valid <= 1'b0;
        while (pending_outputs.size() != 0) @(posedge clk);
        repeat (60) @(posedge clk);
    endtask

    task automatic set_reg(cfg_idx_t idx, int v);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= CFG_DAT_W'(v);
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx < NUM_REGS) shape[idx] = v & reg_mask[idx];
        @(posedge clk);
    endtask

    task automatic set_shape(int ih, int iw, int ch, int kr, int kc, int nf, int be);
        drain();
        set_reg(REG_IN_HEIGHT, ih);
        set_reg(REG_IN_WIDTH, iw);
        set_reg(REG_CHANNELS, ch);
        set_reg(REG_KERNEL_ROWS, kr);
        set_reg(REG_KERNEL_COLS, kc);
        set_reg(REG_FILTERS, nf);
        set_reg(REG_BIAS_ENABLE, be);
    endtask

    task automatic query(bit out_of_range);
        int     cnt;
        int     a;
        longint acc;
        cnt = output_count();
        a   = -1;
        if (out_of_range || cnt == 0)
        begin
            if (cnt < 16384) a = $urandom_range(cnt, 16383);
        end
        else
            for (int t = 0; t < 300 && a < 0; t++)
            begin
                a = $urandom_range(0, cnt - 1);
                if (!walk_window(a, 1, acc)) a = -1;
            end
        if (a >= 0) send(OP_COMPUTE, ADDR_W'(a), 16'($urandom));
    endtask

    // load the stores (activations below act_lim), then mix queries with noise
    task automatic run_shape(int act_lim, int nq);
        int n_act, n_wgt;
        n_act = shape[REG_IN_HEIGHT] * shape[REG_IN_WIDTH] * shape[REG_CHANNELS];
        n_wgt = shape[REG_KERNEL_ROWS] * shape[REG_KERNEL_COLS] *
                shape[REG_CHANNELS] * shape[REG_FILTERS];
        if (act_lim < n_act) n_act = act_lim;
        for (int i = 0; i < n_act; i++) send(OP_LOAD_ACT, ADDR_W'(i), rand_q88());
        for (int i = 0; i < n_wgt; i++)
        begin
            send(OP_LOAD_WGT, ADDR_W'(i), rand_q88());
            if ($urandom_range(0, 9) == 0)
                send(OP_LOAD_WGT, ADDR_W'($urandom_range(WGT_DEPTH, 16383)), rand_q88());
        end
        for (int i = 0; i < shape[REG_FILTERS]; i++)
            send(OP_LOAD_BIAS, ADDR_W'(i), rand_q88());
        for (int i = 0; i < nq; i++)
        begin
            case ($urandom_range(0, 9))
                0: query(1);
                1: send(OP_LOAD_ACT, ADDR_W'($urandom_range(0, n_act - 1)), rand_q88());
                2: send(OP_LOAD_BIAS, ADDR_W'($urandom_range(BIAS_DEPTH, 16383)), rand_q88());
                default: query(0);
            endcase
        end
    endtask

    stim_row_t directed[] = '{
        '{OP_LOAD_ACT,  0,     16'h7FFF, 0, 0,       0},
        '{OP_LOAD_WGT,  0,     16'h7FFF, 0, 0,       0},
        '{OP_LOAD_BIAS, 0,     16'h7FFF, 0, 0,       0},
        '{OP_COMPUTE,   0,     16'hFFFF, 1, RES_MAX, 0},
        '{OP_COMPUTE,   1,     16'h0000, 1, 0,       1},
        '{OP_COMPUTE,   16383, 16'h0000, 1, 0,       1},
        '{OP_LOAD_ACT,  0,     16'h8000, 0, 0,       0},
        '{OP_COMPUTE,   0,     16'h0000, 1, 0,       0},
        '{OP_LOAD_WGT,  0,     16'h8000, 0, 0,       0},
        '{OP_LOAD_BIAS, 0,     16'h8000, 0, 0,       0},
        '{OP_COMPUTE,   0,     16'h0000, 1, RES_MAX, 0},
        '{OP_LOAD_WGT,  6400,  16'h1234, 0, 0,       0},
        '{OP_LOAD_WGT,  16383, 16'h5555, 0, 0,       0},
        '{OP_LOAD_BIAS, 16,    16'h4321, 0, 0,       0},
        '{OP_LOAD_BIAS, 16383, 16'h2AAA, 0, 0,       0},
        '{OP_COMPUTE,   0,     16'h0000, 1, RES_MAX, 0},
        '{OP_LOAD_ACT,  16383, 16'h0000, 0, 0,       0},
        '{OP_LOAD_ACT,  0,     16'h0100, 0, 0,       0},
        '{OP_LOAD_WGT,  0,     16'h0180, 0, 0,       0},
        '{OP_LOAD_BIAS, 0,     16'hFF80, 0, 0,       0},
        '{OP_COMPUTE,   0,     16'h0000, 0, 0,       0}
    };

    initial
    begin
        int ih, iw, kr, kc;
        foreach (shape[i]) shape[i] = 1;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed[i])
            send(directed[i].op, directed[i].addr, directed[i].value,
                 directed[i].typed, directed[i].result, directed[i].status);

        // largest map: load only the top row, query inside it
        set_shape(32, 32, 1, 1, 1, 1, 1);
        run_shape(32, 12);
        // largest kernel
        set_shape(5, 5, 1, 5, 5, 1, 1);
        run_shape(ACT_DEPTH, 8);
        // deepest channels, then most filters
        set_shape(1, 1, 16, 1, 1, 4, 1);
        run_shape(ACT_DEPTH, 12);
        set_shape(1, 2, 1, 1, 1, 16, 0);
        run_shape(ACT_DEPTH, 10);

        for (int p = 0; p < 5; p++)
        begin
            quiet = ($urandom_range(0, 3) == 0);
            ih = $urandom_range(1, 6);
            iw = $urandom_range(1, 6);
            kr = $urandom_range(1, (ih < 3) ? ih : 3);
            kc = $urandom_range(1, (iw < 3) ? iw : 3);
            set_shape(ih, iw, $urandom_range(1, 3), kr, kc, $urandom_range(1, 3),
                      $urandom_range(0, 1));
            if (p == 3) set_reg(cfg_idx_t'(NUM_REGS), $urandom_range(0, 63));
            run_shape(ACT_DEPTH, $urandom_range(10, 24));
        end
        quiet = 1'b0;

        // edge values in each shape register, most illegal: a compute on an illegal shape must come back with an error
        set_shape(3, 3, 1, 2, 2, 1, 0);
        foreach (reg_mask[r])
            for (int k = 0; k < 3; k++)
            begin
                drain();
                case (k)
                    0: set_reg(cfg_idx_t'(r), 0);
                    1: set_reg(cfg_idx_t'(r), 63);
                    default: set_reg(cfg_idx_t'(r), reg_mask[r] == 31 ? 17 : 33);
                endcase
                query(0);
                query(1);
                drain();
                set_shape(3, 3, 1, 2, 2, 1, 0);
            end
        set_shape(2, 3, 1, 3, 2, 1, 0);
        query(0);
        set_shape(3, 2, 1, 2, 3, 1, 0);
        query(0);
        set_shape(3, 3, 1, 2, 2, 1, 1);
        run_shape(ACT_DEPTH, 10);

        drain();
        repeat (500) @(posedge clk);
        if (mismatches == 0)
            $display("conv2d_valid_bias_relu_core regression: pass");
        else
            $display("conv2d_valid_bias_relu_core regression: fail");
        $finish;
    end

endmodule

`default_nettype wire

// File: files.f
rtl/cdbr_pkg.sv
rtl/cdbr_div.sv
rtl/cdbr_stores.sv
rtl/cdbr_mac.sv
rtl/conv2d_valid_bias_relu_core.sv
bench/testbench.sv
